@@ src/bafc_pkg.sv @@
// bafc_pkg: shared types and constants for the bit-aligned field copier
// no dependencies; used by bafc_merge and bit_aligned_field_copier
package bafc_pkg;

  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 3;
  localparam int BIT_COUNT_W = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = BIT_COUNT_W;
  localparam int SHIFT_W     = 4;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIT_ORDER  = 2'd0,
    CFG_DST_OFFSET = 2'd1,
    CFG_SRC_OFFSET = 2'd2,
    CFG_BIT_COUNT  = 2'd3
  } cfg_index_t;

  // bit numbering of a byte
  typedef enum logic {
    ORDER_MSB_FIRST = 1'b0,
    ORDER_LSB_FIRST = 1'b1
  } bit_order_t;

  // per-byte controls for the shift-merge
  typedef struct packed {
    bit_order_t         order;
    logic [SHIFT_W-1:0] win_pos;  // window position of destination bit 0, 1..8
    logic [OFFSET_W-1:0] lo_pos;  // first covered bit position
    logic [SHIFT_W-1:0] hi_pos;   // one past the last covered position, 1..8
  } merge_ctl_t;

endpackage

@@ src/bafc_merge.sv @@
// bafc_merge: two-byte window shift and masked merge into the old destination byte
// depends on bafc_pkg
module bafc_merge (
  input  logic [bafc_pkg::BYTE_W-1:0] held_byte,
  input  logic [bafc_pkg::BYTE_W-1:0] src_byte,
  input  logic [bafc_pkg::BYTE_W-1:0] dst_byte,
  input  bafc_pkg::merge_ctl_t        ctl,
  output logic [bafc_pkg::BYTE_W-1:0] res_byte
);

  logic [2*bafc_pkg::BYTE_W-1:0] win_msb;
  logic [2*bafc_pkg::BYTE_W-1:0] win_lsb;
  logic [2*bafc_pkg::BYTE_W-1:0] shifted;
  logic [bafc_pkg::BYTE_W-1:0]   val;
  logic [bafc_pkg::BYTE_W-1:0]   lo_m;
  logic [bafc_pkg::BYTE_W-1:0]   hi_m;
  logic [bafc_pkg::BYTE_W-1:0]   mask;
  logic [bafc_pkg::SHIFT_W-1:0]  msb_shift;

  assign win_msb   = {held_byte, src_byte};
  assign win_lsb   = {src_byte, held_byte};
  assign msb_shift = bafc_pkg::SHIFT_W'(bafc_pkg::BYTE_W) - ctl.win_pos;

  always_comb begin
    if (ctl.order == bafc_pkg::ORDER_MSB_FIRST) begin
      shifted = win_msb >> msb_shift;
      lo_m    = 8'hff >> ctl.lo_pos;
      hi_m    = 8'hff >> ctl.hi_pos;
    end else begin
      shifted = win_lsb >> ctl.win_pos;
      lo_m    = 8'hff << ctl.lo_pos;
      hi_m    = 8'hff << ctl.hi_pos;
    end
    val  = shifted[bafc_pkg::BYTE_W-1:0];
    mask = lo_m & ~hi_m;
  end

  assign res_byte = ((val ^ dst_byte) & mask) ^ dst_byte;

endmodule

@@ src/bit_aligned_field_copier.sv @@
// bit_aligned_field_copier: top level, input register, transfer state, result register
// depends on bafc_pkg and bafc_merge
//
// Copies bit_count bits from a source byte stream starting at bit src_offset into a
// destination stream starting at bit dst_offset, MSB-first or LSB-first per bit_order.
// Send one item per destination byte (source byte plus the old destination byte), and
// one extra leading item when src_offset > dst_offset; that item only loads the held
// source byte and gives no result. The final result carries out_last. A bit_count of
// zero returns dst_byte unchanged with out_last set; counts above MAX_BITS saturate.
// One item per cycle is sustained while out_stall is low: an item sits in an input
// register, the shift-merge is one shallow stage into the result register, and the
// input register holds one item while a result waits under out_stall. Any write ends
// a transfer; the user must write registers only while idle (the block does not enforce it).
module bit_aligned_field_copier #(
  parameter int MAX_BITS = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bafc_pkg::BYTE_W-1:0]         in_src_byte,
  input  logic [bafc_pkg::BYTE_W-1:0]         in_dst_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bafc_pkg::BYTE_W-1:0]         out_byte,
  output logic                                out_last,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bafc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bafc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // bits_left holds up to dst_offset + MAX_BITS
  localparam int CNT_W = $clog2(MAX_BITS + 8);
  localparam int CMP_W = (CNT_W > bafc_pkg::BIT_COUNT_W) ? CNT_W : bafc_pkg::BIT_COUNT_W;
  localparam logic [CMP_W-1:0] MAX_C  = CMP_W'(MAX_BITS);
  localparam logic [CNT_W-1:0] BYTE_C = CNT_W'(bafc_pkg::BYTE_W);

  // configuration registers
  bafc_pkg::bit_order_t                 bit_order_r;
  logic [bafc_pkg::OFFSET_W-1:0]        dst_offset_r;
  logic [bafc_pkg::OFFSET_W-1:0]        src_offset_r;
  logic [bafc_pkg::BIT_COUNT_W-1:0]     bit_count_r;

  // input register
  logic                                 in_valid_r, in_valid_nxt;
  logic [bafc_pkg::BYTE_W-1:0]          in_src_r;
  logic [bafc_pkg::BYTE_W-1:0]          in_dst_r;

  // transfer state
  logic [bafc_pkg::BYTE_W-1:0]          held_r, held_nxt;
  logic [CNT_W-1:0]                     bits_left_r, bits_left_nxt;
  logic                                 primed_r, primed_nxt;
  logic                                 first_done_r, first_done_nxt;

  // result register
  logic                                 out_valid_r, out_valid_nxt;
  logic [bafc_pkg::BYTE_W-1:0]          out_byte_r, out_byte_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                                 in_xfer;
  logic                                 cfg_xfer;
  logic                                 proc;       // item in the input register is worked now
  logic                                 starting;
  logic [CMP_W-1:0]                     count_ext;
  logic [CNT_W-1:0]                     count_sat;
  logic [CNT_W-1:0]                     bl_eff;
  logic                                 primed_eff;
  logic                                 first_done_eff;
  logic                                 is_last;
  bafc_pkg::merge_ctl_t                 ctl;
  logic [bafc_pkg::BYTE_W-1:0]          merged;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // the input register drains when the result register is free or being emptied
  assign proc     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proc;
  assign in_xfer  = in_valid && !in_stall;

  // transfer start values
  assign starting  = (bits_left_r == '0);
  assign count_ext = CMP_W'(bit_count_r);
  assign count_sat = (count_ext > MAX_C) ? CNT_W'(MAX_C) : CNT_W'(count_ext);

  always_comb begin
    if (starting) begin
      bl_eff         = count_sat + CNT_W'(dst_offset_r);
      primed_eff     = !(src_offset_r > dst_offset_r);
      first_done_eff = 1'b0;
    end else begin
      bl_eff         = bits_left_r;
      primed_eff     = primed_r;
      first_done_eff = first_done_r;
    end
  end

  assign is_last = (bl_eff <= BYTE_C);

  // merge controls for this byte
  always_comb begin
    ctl.order = bit_order_r;
    if (dst_offset_r >= src_offset_r) begin
      ctl.win_pos = bafc_pkg::SHIFT_W'(bafc_pkg::BYTE_W)
                    - bafc_pkg::SHIFT_W'(dst_offset_r - src_offset_r);
    end else begin
      ctl.win_pos = bafc_pkg::SHIFT_W'(src_offset_r - dst_offset_r);
    end
    ctl.lo_pos = first_done_eff ? '0 : dst_offset_r;
    ctl.hi_pos = (bl_eff >= BYTE_C) ? bafc_pkg::SHIFT_W'(bafc_pkg::BYTE_W)
                                    : bl_eff[bafc_pkg::SHIFT_W-1:0];
  end

  bafc_merge u_merge (
    .held_byte (held_r),
    .src_byte  (in_src_r),
    .dst_byte  (in_dst_r),
    .ctl       (ctl),
    .res_byte  (merged)
  );

  // next state of the transfer and the result register
  always_comb begin
    held_nxt       = held_r;
    bits_left_nxt  = bits_left_r;
    primed_nxt     = primed_r;
    first_done_nxt = first_done_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (cfg_xfer) begin
      // any register write ends the transfer
      bits_left_nxt  = '0;
      primed_nxt     = 1'b0;
      first_done_nxt = 1'b0;
    end else if (proc) begin
      held_nxt = in_src_r;
      if (starting && (bit_count_r == '0)) begin
        // zero count: pass the old byte through, stay idle
        out_valid_nxt = 1'b1;
        out_byte_nxt  = in_dst_r;
        out_last_nxt  = 1'b1;
      end else if (!primed_eff) begin
        // priming item, no result
        bits_left_nxt  = bl_eff;
        primed_nxt     = 1'b1;
        first_done_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = merged;
        out_last_nxt  = is_last;
        if (is_last) begin
          bits_left_nxt  = '0;
          primed_nxt     = 1'b0;
          first_done_nxt = 1'b0;
        end else begin
          bits_left_nxt  = bl_eff - BYTE_C;
          primed_nxt     = 1'b1;
          first_done_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (proc) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_order_r  <= bafc_pkg::ORDER_MSB_FIRST;
      dst_offset_r <= '0;
      src_offset_r <= '0;
      bit_count_r  <= bafc_pkg::BIT_COUNT_W'(8);
      in_valid_r   <= 1'b0;
      held_r       <= '0;
      bits_left_r  <= '0;
      primed_r     <= 1'b0;
      first_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        unique case (bafc_pkg::cfg_index_t'(cfg_index))
          bafc_pkg::CFG_BIT_ORDER: begin
            bit_order_r <= bafc_pkg::bit_order_t'(cfg_data[0]);
          end
          bafc_pkg::CFG_DST_OFFSET: begin
            dst_offset_r <= cfg_data[bafc_pkg::OFFSET_W-1:0];
          end
          bafc_pkg::CFG_SRC_OFFSET: begin
            src_offset_r <= cfg_data[bafc_pkg::OFFSET_W-1:0];
          end
          bafc_pkg::CFG_BIT_COUNT: begin
            bit_count_r <= cfg_data[bafc_pkg::BIT_COUNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      in_valid_r   <= in_valid_nxt;
      held_r       <= held_nxt;
      bits_left_r  <= bits_left_nxt;
      primed_r     <= primed_nxt;
      first_done_r <= first_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_src_r <= in_src_byte;
      in_dst_r <= in_dst_byte;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule
